[rtl/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types and constants for the hashed slot allocator: table geometry,
// hash constants, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hsa_pkg;

    // Table geometry
    localparam int TABLE_SIZE     = 1024;
    localparam int TABLE_BITS     = 10;
    localparam int WORD_W         = 32;                    // slots per bitmap row
    localparam int WORD_IDX_BITS  = 5;
    localparam int NUM_ROWS       = TABLE_SIZE / WORD_W;
    localparam int ROW_BITS       = TABLE_BITS - WORD_IDX_BITS;
    localparam int COUNT_BITS     = TABLE_BITS + 1;

    // Slots handed out per host
    localparam int SLOTS_PER_HOST = 8;
    localparam int K_BITS         = 3;

    // Field widths
    localparam int HOST_W         = 16;
    localparam int SLOT_W         = 10;

    // MurmurHash64A constants
    localparam logic [63:0] HASH_SEED = 64'h0000_0000_dead_beef;
    localparam logic [63:0] MIX_MUL   = 64'hc6a4_a793_5bd1_e995;
    localparam logic [63:0] HASH_INIT = HASH_SEED ^ (MIX_MUL << 3);  // seed ^ (len * m)
    localparam int          MIX_SHIFT = 47;

    // Multiplier sub-steps (one 32x32 partial product per step, then post op)
    localparam logic [1:0] MSTEP_LL   = 2'd0;
    localparam logic [1:0] MSTEP_HL   = 2'd1;
    localparam logic [1:0] MSTEP_LH   = 2'd2;
    localparam logic [1:0] MSTEP_POST = 2'd3;

    // Operation applied after a 64-bit multiply completes
    typedef enum logic {
        POST_SHIFT,     // x ^= x >> 47
        POST_SEED       // x ^= initial hash state
    } t_post;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_PINIT,
        ST_RD,
        ST_CHK,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       load_host;  // capture host id, clear request counter
        logic       next_k;     // advance to next request
        logic       load_key;   // x <= key
        logic       mul_en;     // run one multiplier sub-step
        logic [1:0] mul_step;
        t_post      post;
        logic       probe_init; // home slot from hash
        logic       rd;         // read bitmap row
        logic       commit;     // mark free slot, record result
        logic       advance;    // move to next row
        logic       set_full;   // record a table-full result
        logic       emit;       // load output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } t_status;

endpackage

[rtl/hsa_datapath.sv]
// ----------------------------------------------------------------------------
// hsa_datapath
// Hash engine with a shared 32x32 multiplier, row-wide bitmap memory with
// per-row valid flags, probe logic and the output register.
// ----------------------------------------------------------------------------
module hsa_datapath
    import hsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [HOST_W-1:0]   i_host_id,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic                o_last_slot,
    output logic                o_table_full
);

    // Request context
    logic [HOST_W-1:0]         r_host;
    logic [K_BITS-1:0]         r_k;

    // Hash engine
    logic [63:0]               r_x;
    logic [63:0]               r_acc;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic [63:0]               post_val;
    logic [63:0]               key;

    // Bitmap and probe
    logic [WORD_W-1:0]         r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]       r_row_vld;
    logic [WORD_W-1:0]         r_rdata;
    logic                      r_rvalid;
    logic [ROW_BITS-1:0]       r_row;
    logic [WORD_IDX_BITS-1:0]  r_off;
    logic                      r_first;
    logic [COUNT_BITS-1:0]     r_used;
    logic [WORD_W-1:0]         row_data;
    logic [WORD_W-1:0]         free_mask;
    logic [WORD_IDX_BITS-1:0]  pick;

    // Result holding and output register
    logic [SLOT_W-1:0]         r_res_slot;
    logic                      r_res_full;
    logic                      r_o_valid;
    logic [SLOT_W-1:0]         r_o_slot;
    logic                      r_o_last;
    logic                      r_o_full;

    // Key = host * TABLE_SIZE + k
    assign key = {{(64 - HOST_W - TABLE_BITS){1'b0}}, r_host,
                  {(TABLE_BITS - K_BITS){1'b0}}, r_k};

    // Partial product operand select
    always_comb begin
        mul_a = r_x[31:0];
        mul_b = MIX_MUL[31:0];
        case (i_cmd.mul_step)
            MSTEP_HL: mul_a = r_x[63:32];
            MSTEP_LH: mul_b = MIX_MUL[63:32];
            default:  ;
        endcase
    end
    // 32x32 partial product, operands zero-extended to the product width
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Post-multiply mixing
    always_comb begin
        case (i_cmd.post)
            POST_SEED: post_val = r_acc ^ HASH_INIT;
            default:   post_val = r_acc ^ (r_acc >> MIX_SHIFT);
        endcase
    end

    // Probe: first free slot in the row, masked below the home offset on first row
    assign row_data  = r_rvalid ? r_rdata : '0;
    assign free_mask = ~row_data & (r_first ? ({WORD_W{1'b1}} << r_off) : {WORD_W{1'b1}});

    always_comb begin
        pick = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_mask[i]) begin
                pick = WORD_IDX_BITS'(i);
            end
        end
    end

    // Context and hash registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_host) begin
            r_host <= i_host_id;
        end
        if (i_cmd.load_host) begin
            r_k <= '0;
        end else if (i_cmd.next_k) begin
            r_k <= r_k + K_BITS'(1);
        end
        if (i_cmd.load_key) begin
            r_x <= key;
        end else if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                MSTEP_LL:   r_acc <= mul_p;
                MSTEP_HL,
                MSTEP_LH:   r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
                MSTEP_POST: r_x <= post_val;
                default:    ;
            endcase
        end
    end

    // Probe position
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_row   <= r_x[TABLE_BITS-1:WORD_IDX_BITS];
            r_off   <= r_x[WORD_IDX_BITS-1:0];
            r_first <= 1'b1;
        end else if (i_cmd.advance) begin
            r_row   <= r_row + ROW_BITS'(1);
            r_first <= 1'b0;
        end
    end

    // Bitmap memory, one row per word
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_row];
        end
        if (i_cmd.commit) begin
            r_mem[r_row] <= row_data | (WORD_W'(1) << pick);
        end
    end

    // Row valid flags and occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rvalid  <= 1'b0;
            r_used    <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_rvalid <= r_row_vld[r_row];
            end
            if (i_cmd.commit) begin
                r_row_vld[r_row] <= 1'b1;
                r_used           <= r_used + COUNT_BITS'(1);
            end
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_slot <= SLOT_W'({r_row, pick});
            r_res_full <= 1'b0;
        end else if (i_cmd.set_full) begin
            r_res_slot <= '0;
            r_res_full <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_slot <= r_res_slot;
            r_o_full <= r_res_full;
            r_o_last <= (r_k == K_BITS'(SLOTS_PER_HOST - 1));
        end
    end

    assign o_status.full     = (r_used == COUNT_BITS'(TABLE_SIZE));
    assign o_status.hit      = |free_mask;
    assign o_status.last     = (r_k == K_BITS'(SLOTS_PER_HOST - 1));
    assign o_status.out_free = !r_o_valid || !i_out_stall;

    assign o_out_valid  = r_o_valid;
    assign o_slot_index = r_o_slot;
    assign o_last_slot  = r_o_last;
    assign o_table_full = r_o_full;

endmodule

[rtl/hsa_ctrl.sv]
// ----------------------------------------------------------------------------
// hsa_ctrl
// Sequencer: per request it hands out a result; unless the table is full it
// runs four 64-bit multiplies on the shared multiplier and walks bitmap rows.
// ----------------------------------------------------------------------------
module hsa_ctrl
    import hsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state     r_state, n_state;
    logic [1:0] r_mstep, n_mstep;   // sub-step within one multiply
    logic [1:0] r_mcnt,  n_mcnt;    // which of the four multiplies

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mstep <= '0;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_mstep <= n_mstep;
            r_mcnt  <= n_mcnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_mstep    = r_mstep;
        n_mcnt     = r_mcnt;
        o_cmd      = '0;
        o_cmd.post = (r_mcnt == 2'd1) ? POST_SEED : POST_SHIFT;
        o_cmd.mul_step = r_mstep;
        o_in_stall = 1'b1;

        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_host = 1'b1;
                    n_state         = ST_START;
                end
            end
            ST_START: begin
                if (i_status.full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = ST_EMIT;
                end else begin
                    o_cmd.load_key = 1'b1;
                    n_mstep        = MSTEP_LL;
                    n_mcnt         = '0;
                    n_state        = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_mstep      = r_mstep + 2'd1;
                if (r_mstep == MSTEP_POST) begin
                    n_mcnt = r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        n_state = ST_PINIT;
                    end
                end
            end
            ST_PINIT: begin
                o_cmd.probe_init = 1'b1;
                n_state          = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                if (i_status.hit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_RD;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.next_k = 1'b1;
                        n_state      = ST_START;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/hashed_slot_allocator.sv]
// ----------------------------------------------------------------------------
// hashed_slot_allocator
// Allocates SLOTS_PER_HOST table slots per host id by MurmurHash64A and
// linear probing over a used-slot bitmap.
// ----------------------------------------------------------------------------
// Each accepted host id yields 8 results in order, the last one flagged. For
// each slot the sequencer runs a setup step, the four 64-bit multiplies of
// the hash on one shared 32x32 multiplier (three partial products and a
// mixing step each), a step to form the home slot, then for each 32-slot
// bitmap row probed a registered memory read and a search, and last the
// hand-off of the result to the output register. Once the table is full a
// result needs only the setup step and the hand-off. Accepting a host id is
// a step of its own; a new host id is accepted as soon as the last result of
// the previous run has been loaded into the output register, while that
// result may still be waiting there. A stalled output holds the run at its
// next hand-off. The bitmap is cleared by per-row valid flags at reset, so
// the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module hashed_slot_allocator
    import hsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [HOST_W-1:0] i_host_id,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic              o_last_slot,
    output logic              o_table_full
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    hsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // Hash, bitmap and output datapath
    hsa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_host_id    (i_host_id),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_slot_index (o_slot_index),
        .o_last_slot  (o_last_slot),
        .o_table_full (o_table_full)
    );

    // A full-table result never carries a slot
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_slot_index == '0)
        else $error("table_full result with nonzero slot index");

    // No new host while a run is still being handed out
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_slot |-> o_stall)
        else $error("input ready in the middle of a run");

    // An accepted host id starts a run that blocks input
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input ready right after an accepted transaction");

endmodule
